// ----- rtl/cpts_pkg.sv -----
`default_nettype none
package cpts_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_SCHED = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_TICK_RD,
    ST_TICK_WR,
    ST_WAKE_RD,
    ST_WAKE_WR,
    ST_PICK_RD,
    ST_PICK_CMP,
    ST_PICK_END,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_SLOT_WR,
    ST_SLOT_RD,
    ST_SLOT_OUT,
    ST_DONE
  } state_t;

  localparam logic [2:0]  RUN_RUNNING  = 3'd0;
  localparam logic [2:0]  RUN_INTERRUPT = 3'd1;
  localparam logic [7:0]  INIT_SLICE   = 8'd15;
  localparam logic [6:0]  INIT_PRIO    = 7'd15;
  localparam logic [31:0] KILL_STOP_MASK = (32'd1 << 8) | (32'd1 << 18);
  localparam logic [31:0] ALRM_MASK    = 32'd1 << 13;

  // entry layout: present, run state, priority, counter, alarm, pending, blocked,
  // user ticks, system ticks
  localparam int ENTRY_W = 1 + 3 + 7 + 8 + 32 * 5;

  typedef struct packed {
    logic        present;
    logic [2:0]  run_state;
    logic [6:0]  priority_v;
    logic [7:0]  counter;
    logic [31:0] alarm;
    logic [31:0] pending;
    logic [31:0] blocked;
    logic [31:0] uticks;
    logic [31:0] sticks;
  } entry_t;

  typedef enum logic [2:0] {
    WOP_NONE,
    WOP_CLEAR,
    WOP_TICK,
    WOP_WAKE,
    WOP_FILL,
    WOP_SLOT
  } wop_t;

  typedef struct packed {
    logic       rd_en;
    logic       rd_run;
    wop_t       wop;
    logic       pick_clear;
    logic       pick_cmp;
    logic       cap_read;
    logic       tick_inc;
    logic       set_run;
  } cmd_t;

  typedef struct packed {
    logic       best_zero;
    logic       best_none;
    logic       counter_le1;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/cpts_ram.sv -----
`default_nettype none
module cpts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/cpts_datapath.sv -----
`default_nettype none
module cpts_datapath #(
  parameter int NUM_TASKS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cpts_pkg::cmd_t    cmd,
  input  wire logic [$clog2(NUM_TASKS)-1:0] addr,
  input  wire logic              in_load,
  input  wire logic [1:0]        in_cpl,
  input  wire logic [5:0]        in_slot_index,
  input  wire logic              in_slot_present,
  input  wire logic [2:0]        in_slot_run_state,
  input  wire logic [6:0]        in_slot_priority,
  input  wire logic [7:0]        in_slot_counter,
  input  wire logic [31:0]       in_slot_alarm,
  input  wire logic [31:0]       in_slot_signal,
  input  wire logic [31:0]       in_slot_blocked,
  output cpts_pkg::sts_t         sts,
  output logic [$clog2(NUM_TASKS)-1:0] run_slot,
  output logic [$clog2(NUM_TASKS)-1:0] best_slot,
  output logic [2:0]             rd_run_state,
  output logic [7:0]             rd_counter,
  output logic [31:0]            rd_signal,
  output logic [31:0]            rd_user_ticks,
  output logic [31:0]            rd_system_ticks
);
  localparam int AW = $clog2(NUM_TASKS);

  cpts_pkg::entry_t rdata, wdata;
  logic [AW-1:0]    raddr_r;
  logic             we;
  logic [AW-1:0]    run_r, best_r;
  logic [8:0]       best_c_r;
  logic [31:0]      ticks_r;
  logic [1:0]       cpl_r;
  cpts_pkg::entry_t wr_r;
  logic [2:0]       rs_r;
  logic [7:0]       cn_r;
  logic [31:0]      sg_r, ut_r, st_r;
  logic [31:0]      live;
  logic             alarm_hit;

  cpts_ram #(.WIDTH(cpts_pkg::ENTRY_W), .DEPTH(NUM_TASKS)) u_ram (
    .clk(clk), .we(we), .waddr(addr), .wdata(wdata), .raddr(addr), .rdata(rdata)
  );

  assign alarm_hit = (rdata.alarm != 32'd0) && (rdata.alarm < ticks_r);
  assign live = (rdata.pending | (alarm_hit ? cpts_pkg::ALRM_MASK : 32'd0)) &
                ~(rdata.blocked & ~cpts_pkg::KILL_STOP_MASK);

  always_comb begin
    wdata = rdata;
    we    = 1'b1;
    unique case (cmd.wop)
      cpts_pkg::WOP_CLEAR: begin
        wdata = '0;
        wdata.priority_v = 7'd1;
        if (addr == '0) begin
          wdata.present    = 1'b1;
          wdata.counter    = cpts_pkg::INIT_SLICE;
          wdata.priority_v = cpts_pkg::INIT_PRIO;
        end
      end
      cpts_pkg::WOP_TICK: begin
        if (cpl_r != 2'd0) wdata.uticks = rdata.uticks + 32'd1;
        else wdata.sticks = rdata.sticks + 32'd1;
        wdata.counter = (rdata.counter > 8'd1) ? rdata.counter - 8'd1 : 8'd0;
      end
      cpts_pkg::WOP_WAKE: begin
        we = rdata.present;
        if (alarm_hit) begin
          wdata.pending = rdata.pending | cpts_pkg::ALRM_MASK;
          wdata.alarm   = 32'd0;
        end
        if (live != 32'd0 && rdata.run_state == cpts_pkg::RUN_INTERRUPT)
          wdata.run_state = cpts_pkg::RUN_RUNNING;
      end
      cpts_pkg::WOP_FILL: begin
        we = rdata.present;
        wdata.counter = {1'b0, rdata.counter[7:1]} + {1'b0, rdata.priority_v};
      end
      cpts_pkg::WOP_SLOT: wdata = wr_r;
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    raddr_r <= addr;
    if (!rst_n) begin
      run_r   <= '0;
      ticks_r <= 32'd0;
    end else begin
      if (cmd.tick_inc) ticks_r <= ticks_r + 32'd1;
      if (cmd.set_run) run_r <= best_r;
    end
    if (in_load) begin
      cpl_r          <= in_cpl;
      wr_r.present    <= in_slot_present;
      wr_r.run_state  <= in_slot_run_state;
      wr_r.priority_v <= in_slot_priority;
      wr_r.counter    <= in_slot_counter;
      wr_r.alarm      <= in_slot_alarm;
      wr_r.pending    <= in_slot_signal;
      wr_r.blocked    <= in_slot_blocked;
      wr_r.uticks     <= 32'd0;
      wr_r.sticks     <= 32'd0;
    end
    if (cmd.pick_clear) begin
      best_r   <= '0;
      best_c_r <= 9'h1ff;
    end else if (cmd.pick_cmp) begin
      if (rdata.present && rdata.run_state == cpts_pkg::RUN_RUNNING &&
          (best_c_r == 9'h1ff || {1'b0, rdata.counter} > best_c_r)) begin
        best_r   <= raddr_r;
        best_c_r <= {1'b0, rdata.counter};
      end
    end
    if (cmd.cap_read) begin
      rs_r <= rdata.run_state;
      cn_r <= rdata.counter;
      sg_r <= rdata.pending;
      ut_r <= rdata.uticks;
      st_r <= rdata.sticks;
    end else if (in_load) begin
      rs_r <= 3'd0;
      cn_r <= 8'd0;
      sg_r <= 32'd0;
      ut_r <= 32'd0;
      st_r <= 32'd0;
    end
  end

  assign sts.best_zero   = (best_c_r == 9'd0);
  assign sts.best_none   = (best_c_r == 9'h1ff);
  assign sts.counter_le1 = (rdata.counter <= 8'd1);
  assign run_slot        = run_r;
  assign best_slot       = best_r;
  assign rd_run_state    = rs_r;
  assign rd_counter      = cn_r;
  assign rd_signal       = sg_r;
  assign rd_user_ticks   = ut_r;
  assign rd_system_ticks = st_r;

  logic unused;
  assign unused = ^in_slot_index ^ cmd.rd_en ^ cmd.rd_run;
endmodule
`default_nettype wire

// ----- rtl/cpts_ctrl.sv -----
`default_nettype none
module cpts_ctrl #(
  parameter int NUM_TASKS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [1:0]        in_func,
  input  wire logic [1:0]        in_cpl,
  input  wire logic [5:0]        in_slot_index,
  input  wire cpts_pkg::sts_t    sts,
  input  wire logic [$clog2(NUM_TASKS)-1:0] run_slot,
  output logic                   busy,
  output logic                   in_load,
  output cpts_pkg::cmd_t         cmd,
  output logic [$clog2(NUM_TASKS)-1:0] addr,
  output logic                   out_strobe,
  output logic                   out_switched
);
  localparam int AW = $clog2(NUM_TASKS);
  localparam logic [AW-1:0] TOP = AW'(NUM_TASKS - 1);

  cpts_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [AW-1:0]    before_r;
  logic             filled_r, filled_nxt;
  logic             cpl_r;
  logic             inrange_r;
  logic             read_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= cpts_pkg::ST_CLEAR;
      idx_r    <= '0;
      filled_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      filled_r <= filled_nxt;
    end
    if (in_load) begin
      before_r  <= run_slot;
      cpl_r     <= (in_cpl != 2'd0);
      inrange_r <= ({3'b000, in_slot_index} < 9'(NUM_TASKS));
      read_r    <= (in_func == cpts_pkg::FUNC_READ);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    filled_nxt = filled_r;
    cmd        = '0;
    cmd.wop    = cpts_pkg::WOP_NONE;
    addr       = idx_r;
    busy       = (state_r != cpts_pkg::ST_IDLE);
    in_load    = 1'b0;
    out_strobe = 1'b0;
    unique case (state_r)
      cpts_pkg::ST_CLEAR: begin
        cmd.wop = cpts_pkg::WOP_CLEAR;
        idx_nxt = idx_r + AW'(1);
        if (idx_r == TOP) state_nxt = cpts_pkg::ST_IDLE;
      end
      cpts_pkg::ST_IDLE: begin
        if (start) begin
          in_load = 1'b1;
          filled_nxt = 1'b0;
          idx_nxt = TOP;
          unique case (cpts_pkg::func_t'(in_func))
            cpts_pkg::FUNC_TICK: begin
              cmd.tick_inc = 1'b1;
              state_nxt = cpts_pkg::ST_TICK_RD;
            end
            cpts_pkg::FUNC_SCHED: state_nxt = cpts_pkg::ST_WAKE_RD;
            cpts_pkg::FUNC_WRITE: begin
              idx_nxt = AW'(in_slot_index);
              state_nxt = cpts_pkg::ST_SLOT_WR;
            end
            default: begin
              idx_nxt = AW'(in_slot_index);
              state_nxt = cpts_pkg::ST_SLOT_RD;
            end
          endcase
        end
      end
      cpts_pkg::ST_TICK_RD: begin
        addr = run_slot;
        state_nxt = cpts_pkg::ST_TICK_WR;
      end
      cpts_pkg::ST_TICK_WR: begin
        addr = run_slot;
        cmd.wop = cpts_pkg::WOP_TICK;
        state_nxt = (sts.counter_le1 && cpl_r) ? cpts_pkg::ST_WAKE_RD : cpts_pkg::ST_DONE;
      end
      cpts_pkg::ST_WAKE_RD: state_nxt = cpts_pkg::ST_WAKE_WR;
      cpts_pkg::ST_WAKE_WR: begin
        cmd.wop = cpts_pkg::WOP_WAKE;
        if (idx_r == AW'(1)) begin
          idx_nxt = TOP;
          cmd.pick_clear = 1'b1;
          state_nxt = cpts_pkg::ST_PICK_RD;
        end else begin
          idx_nxt = idx_r - AW'(1);
          state_nxt = cpts_pkg::ST_WAKE_RD;
        end
      end
      cpts_pkg::ST_PICK_RD: state_nxt = cpts_pkg::ST_PICK_CMP;
      cpts_pkg::ST_PICK_CMP: begin
        cmd.pick_cmp = 1'b1;
        if (idx_r == AW'(1)) begin
          idx_nxt = TOP;
          state_nxt = cpts_pkg::ST_PICK_END;
        end else begin
          idx_nxt = idx_r - AW'(1);
          state_nxt = cpts_pkg::ST_PICK_RD;
        end
      end
      // refill once if the best counter is zero
      cpts_pkg::ST_PICK_END: begin
        if (sts.best_zero && !filled_r) begin
          filled_nxt = 1'b1;
          state_nxt = cpts_pkg::ST_FILL_RD;
        end else begin
          cmd.set_run = 1'b1;
          state_nxt = cpts_pkg::ST_DONE;
        end
      end
      cpts_pkg::ST_FILL_RD: state_nxt = cpts_pkg::ST_FILL_WR;
      cpts_pkg::ST_FILL_WR: begin
        cmd.wop = cpts_pkg::WOP_FILL;
        if (idx_r == AW'(1)) begin
          idx_nxt = TOP;
          cmd.pick_clear = 1'b1;
          state_nxt = cpts_pkg::ST_PICK_RD;
        end else begin
          idx_nxt = idx_r - AW'(1);
          state_nxt = cpts_pkg::ST_FILL_RD;
        end
      end
      cpts_pkg::ST_SLOT_WR: begin
        if (inrange_r) cmd.wop = cpts_pkg::WOP_SLOT;
        state_nxt = cpts_pkg::ST_IDLE;
        out_strobe = 1'b1;
      end
      cpts_pkg::ST_SLOT_RD: state_nxt = cpts_pkg::ST_SLOT_OUT;
      cpts_pkg::ST_SLOT_OUT: begin
        if (inrange_r && read_r) cmd.cap_read = 1'b1;
        state_nxt = cpts_pkg::ST_DONE;
      end
      cpts_pkg::ST_DONE: begin
        state_nxt = cpts_pkg::ST_IDLE;
        out_strobe = 1'b1;
      end
      default: state_nxt = cpts_pkg::ST_IDLE;
    endcase
  end

  assign out_switched = 1'b0;
  logic unused;
  assign unused = ^before_r ^ sts.best_none;
endmodule
`default_nettype wire

// ----- rtl/counter_priority_task_scheduler_core.sv -----
`default_nettype none
// Task scheduler over NUM_TASKS slots held in one RAM with a registered read.
// A slot write, a slot read or a tick without rescheduling makes no pass over
// the slots. A schedule walks slots NUM_TASKS-1..1, reading each entry then
// writing it for the wakeup pass, and reading then comparing it for the pick;
// when the best counter of a runnable slot is zero a refill pass and a second
// pick follow. After reset a clearing pass over all NUM_TASKS slots runs with
// busy high. Each result is shown for one cycle on out_valid and must be taken
// then: the receiver cannot stall.
module counter_priority_task_scheduler_core #(
  parameter int NUM_TASKS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [1:0]  in_cpl,
  input  wire logic [5:0]  in_slot_index,
  input  wire logic        in_slot_present,
  input  wire logic [2:0]  in_slot_run_state,
  input  wire logic [6:0]  in_slot_priority,
  input  wire logic [7:0]  in_slot_counter,
  input  wire logic [31:0] in_slot_alarm,
  input  wire logic [31:0] in_slot_signal,
  input  wire logic [31:0] in_slot_blocked,
  output logic             out_valid,
  output logic [5:0]       out_current_slot,
  output logic             out_switched,
  output logic [2:0]       out_rd_run_state,
  output logic [7:0]       out_rd_counter,
  output logic [31:0]      out_rd_signal,
  output logic [31:0]      out_rd_user_ticks,
  output logic [31:0]      out_rd_system_ticks
);
  localparam int AW = $clog2(NUM_TASKS);

  cpts_pkg::cmd_t cmd;
  cpts_pkg::sts_t sts;
  logic [AW-1:0]  addr, run_slot, best_slot, before_r;
  logic           in_load, strobe, sw_unused;

  cpts_ctrl #(.NUM_TASKS(NUM_TASKS)) u_ctrl (
    .clk, .rst_n, .start, .in_func, .in_cpl, .in_slot_index, .sts, .run_slot,
    .busy, .in_load, .cmd, .addr, .out_strobe(strobe), .out_switched(sw_unused)
  );

  cpts_datapath #(.NUM_TASKS(NUM_TASKS)) u_dp (
    .clk, .rst_n, .cmd, .addr, .in_load, .in_cpl, .in_slot_index, .in_slot_present,
    .in_slot_run_state, .in_slot_priority, .in_slot_counter, .in_slot_alarm,
    .in_slot_signal, .in_slot_blocked, .sts, .run_slot, .best_slot,
    .rd_run_state(out_rd_run_state), .rd_counter(out_rd_counter),
    .rd_signal(out_rd_signal), .rd_user_ticks(out_rd_user_ticks),
    .rd_system_ticks(out_rd_system_ticks)
  );

  always_ff @(posedge clk) begin
    if (in_load) before_r <= run_slot;
  end

  assign out_valid        = strobe;
  assign out_current_slot = 6'(run_slot);
  assign out_switched     = (run_slot != before_r);

  logic unused;
  assign unused = ^best_slot ^ sw_unused;

  property p_busy_after_start;
    @(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy;
  endproperty
  assert property (p_busy_after_start) else $error("busy not raised");

  property p_no_strobe_idle;
    @(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid;
  endproperty
  assert property (p_no_strobe_idle) else $error("double result strobe");

  property p_strobe_busy;
    @(posedge clk) disable iff (!rst_n) out_valid |-> busy;
  endproperty
  assert property (p_strobe_busy) else $error("result outside an item");
endmodule
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
module tb;

  localparam int NSLOT = 64;
  localparam int LIMIT = 2000000;
  localparam logic [31:0] KILL_BIT = 32'd1 << 8;

  typedef struct {
    cpts_pkg::func_t fn;
    logic [1:0]  cpl;
    logic [5:0]  idx;
    logic        pres;
    logic [2:0]  rs;
    logic [6:0]  prio;
    logic [7:0]  ctr;
    logic [31:0] alarm;
    logic [31:0] sig;
    logic [31:0] blk;
  } job_t;

  typedef struct {
    logic [5:0]  slot;
    logic        sw;
    logic [2:0]  rs;
    logic [7:0]  ctr;
    logic [31:0] sig;
    logic [31:0] ut;
    logic [31:0] st;
  } res_t;

  typedef struct {
    job_t job;
    bit   typed;
    res_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_func = '0;
  logic [1:0] in_cpl = '0;
  logic [5:0] in_slot_index = '0;
  logic in_slot_present = 1'b0;
  logic [2:0] in_slot_run_state = '0;
  logic [6:0] in_slot_priority = '0;
  logic [7:0] in_slot_counter = '0;
  logic [31:0] in_slot_alarm = '0;
  logic [31:0] in_slot_signal = '0;
  logic [31:0] in_slot_blocked = '0;
  logic out_valid;
  logic [5:0] out_current_slot;
  logic out_switched;
  logic [2:0] out_rd_run_state;
  logic [7:0] out_rd_counter;
  logic [31:0] out_rd_signal, out_rd_user_ticks, out_rd_system_ticks;

  counter_priority_task_scheduler_core #(.NUM_TASKS(NSLOT)) dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // scheduler mirror
  logic        m_pres[NSLOT];
  logic [2:0]  m_rs[NSLOT];
  logic [7:0]  m_ctr[NSLOT];
  logic [6:0]  m_prio[NSLOT];
  logic [31:0] m_alarm[NSLOT], m_pend[NSLOT], m_blk[NSLOT], m_ut[NSLOT], m_st[NSLOT];
  logic [5:0]  m_cur;
  logic [31:0] m_ticks;

  res_t pending_res[$];
  row_t rows[$];
  int   fails = 0;
  int   cycles = 0;

  function automatic void mirror_reset();
    for (int i = 0; i < NSLOT; i++) begin
      m_pres[i] = 1'b0; m_rs[i] = '0; m_ctr[i] = '0; m_prio[i] = 7'd1;
      m_alarm[i] = '0; m_pend[i] = '0; m_blk[i] = '0; m_ut[i] = '0; m_st[i] = '0;
    end
    m_pres[0] = 1'b1;
    m_ctr[0] = cpts_pkg::INIT_SLICE;
    m_prio[0] = cpts_pkg::INIT_PRIO;
    m_cur = '0;
    m_ticks = '0;
  endfunction

  function automatic logic [5:0] best_slot(output int best);
    logic [5:0] nxt;
    best = -1;
    nxt = '0;
    for (int i = NSLOT - 1; i >= 1; i--)
      if (m_pres[i] && m_rs[i] == cpts_pkg::RUN_RUNNING && int'(m_ctr[i]) > best) begin
        best = m_ctr[i];
        nxt = i[5:0];
      end
    return nxt;
  endfunction

  function automatic void reschedule();
    int best;
    logic [5:0] nxt;
    for (int i = NSLOT - 1; i >= 1; i--) begin
      if (!m_pres[i]) continue;
      if (m_alarm[i] != 0 && m_alarm[i] < m_ticks) begin
        m_pend[i] |= cpts_pkg::ALRM_MASK;
        m_alarm[i] = '0;
      end
      if ((m_pend[i] & ~(m_blk[i] & ~cpts_pkg::KILL_STOP_MASK)) != 0 &&
          m_rs[i] == cpts_pkg::RUN_INTERRUPT)
        m_rs[i] = cpts_pkg::RUN_RUNNING;
    end
    nxt = best_slot(best);
    if (best == 0) begin
      for (int i = NSLOT - 1; i >= 1; i--)
        if (m_pres[i]) m_ctr[i] = (m_ctr[i] >> 1) + m_prio[i];
      nxt = best_slot(best);
    end
    m_cur = nxt;
  endfunction

  function automatic res_t apply_job(job_t j);
    res_t r;
    logic [5:0] was;
    was = m_cur;
    r = '{default: '0};
    case (j.fn)
      cpts_pkg::FUNC_TICK: begin
        m_ticks++;
        if (j.cpl != 0) m_ut[m_cur]++;
        else m_st[m_cur]++;
        if (m_ctr[m_cur] > 1) m_ctr[m_cur]--;
        else begin
          m_ctr[m_cur] = '0;
          if (j.cpl != 0) reschedule();
        end
      end
      cpts_pkg::FUNC_SCHED: reschedule();
      cpts_pkg::FUNC_WRITE: begin
        m_pres[j.idx] = j.pres; m_rs[j.idx] = j.rs; m_prio[j.idx] = j.prio;
        m_ctr[j.idx] = j.ctr; m_alarm[j.idx] = j.alarm; m_pend[j.idx] = j.sig;
        m_blk[j.idx] = j.blk; m_ut[j.idx] = '0; m_st[j.idx] = '0;
      end
      default: begin
        r.rs = m_rs[j.idx]; r.ctr = m_ctr[j.idx]; r.sig = m_pend[j.idx];
        r.ut = m_ut[j.idx]; r.st = m_st[j.idx];
      end
    endcase
    r.slot = m_cur;
    r.sw = (m_cur != was);
    return r;
  endfunction

  function automatic job_t mk(cpts_pkg::func_t fn, logic [1:0] cpl, logic [5:0] idx,
                              logic pres = 0, logic [2:0] rs = 0, logic [6:0] prio = 1,
                              logic [7:0] ctr = 0, logic [31:0] al = 0,
                              logic [31:0] sg = 0, logic [31:0] bk = 0);
    job_t j;
    j = '{fn, cpl, idx, pres, rs, prio, ctr, al, sg, bk};
    return j;
  endfunction

  function automatic res_t rv(logic [5:0] slot, logic sw, logic [2:0] rs = 0,
                              logic [7:0] ctr = 0, logic [31:0] sg = 0);
    res_t r;
    r = '{slot, sw, rs, ctr, sg, 32'd0, 32'd0};
    return r;
  endfunction

  function automatic logic [31:0] rand_mask();
    int k;
    k = $urandom_range(9);
    if (k < 5) return '0;
    if (k < 8) return 32'd1 << $urandom_range(31);
    return $urandom;
  endfunction

  function automatic job_t rand_job();
    job_t j;
    int k;
    k = $urandom_range(99);
    j.fn = k < 30 ? cpts_pkg::FUNC_TICK : k < 45 ? cpts_pkg::FUNC_SCHED :
           k < 80 ? cpts_pkg::FUNC_WRITE : cpts_pkg::FUNC_READ;
    j.cpl = 2'($urandom_range(3));
    j.idx = ($urandom_range(9) < 7) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
    j.pres = ($urandom_range(9) < 8);
    k = $urandom_range(19);
    j.rs = k < 12 ? cpts_pkg::RUN_RUNNING : k < 17 ? cpts_pkg::RUN_INTERRUPT :
           3'($urandom_range(7));
    j.prio = ($urandom_range(9) == 0) ? 7'($urandom_range(1)) : 7'($urandom_range(127));
    j.ctr = ($urandom_range(1) == 0) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
    k = $urandom_range(9);
    j.alarm = k < 4 ? 32'd0 : k < 8 ? m_ticks + 32'($urandom_range(20)) - 32'd10 : $urandom;
    j.sig = rand_mask();
    j.blk = rand_mask();
    return j;
  endfunction

  task automatic transfer(job_t j, int idle_pct);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    in_func = j.fn; in_cpl = j.cpl; in_slot_index = j.idx; in_slot_present = j.pres;
    in_slot_run_state = j.rs; in_slot_priority = j.prio; in_slot_counter = j.ctr;
    in_slot_alarm = j.alarm; in_slot_signal = j.sig; in_slot_blocked = j.blk;
    start = 1'b1;
    while (busy) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
    start = 1'b0;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (pending_res.size() == 0) begin
        $error("result with nothing expected, slot %0d", out_current_slot);
        fails++;
      end else begin
        res_t e;
        e = pending_res.pop_front();
        if (out_current_slot !== e.slot) begin
          $error("current_slot exp %0d got %0d", e.slot, out_current_slot); fails++;
        end
        if (out_switched !== e.sw) begin
          $error("switched exp %0d got %0d", e.sw, out_switched); fails++;
        end
        if (out_rd_run_state !== e.rs) begin
          $error("rd_run_state exp %0d got %0d", e.rs, out_rd_run_state); fails++;
        end
        if (out_rd_counter !== e.ctr) begin
          $error("rd_counter exp %0d got %0d", e.ctr, out_rd_counter); fails++;
        end
        if (out_rd_signal !== e.sig) begin
          $error("rd_signal exp %h got %h", e.sig, out_rd_signal); fails++;
        end
        if (out_rd_user_ticks !== e.ut) begin
          $error("rd_user_ticks exp %0d got %0d", e.ut, out_rd_user_ticks); fails++;
        end
        if (out_rd_system_ticks !== e.st) begin
          $error("rd_system_ticks exp %0d got %0d", e.st, out_rd_system_ticks); fails++;
        end
      end
    end
  end

  initial begin
    row_t rw;
    res_t r;
    int idle;
    mirror_reset();
    rows.push_back('{mk(cpts_pkg::FUNC_READ, 0, 0), 1,
                     rv(0, 0, cpts_pkg::RUN_RUNNING, cpts_pkg::INIT_SLICE)});
    rows.push_back('{mk(cpts_pkg::FUNC_READ, 0, 63), 1, rv(0, 0)});
    rows.push_back('{mk(cpts_pkg::FUNC_WRITE, 0, 63, 1, cpts_pkg::RUN_RUNNING, 127, 255,
                        '1, '1, '1), 1, rv(0, 0)});
    rows.push_back('{mk(cpts_pkg::FUNC_SCHED, 0, 0), 1, rv(63, 1)});
    rows.push_back('{mk(cpts_pkg::FUNC_READ, 0, 63), 1,
                     rv(63, 0, cpts_pkg::RUN_RUNNING, 255, '1)});
    rows.push_back('{mk(cpts_pkg::FUNC_TICK, 0, 0), 0, r});
    rows.push_back('{mk(cpts_pkg::FUNC_TICK, 3, 0), 0, r});
    rows.push_back('{mk(cpts_pkg::FUNC_READ, 0, 63), 0, r});
    rows.push_back('{mk(cpts_pkg::FUNC_WRITE, 0, 63), 0, r});
    rows.push_back('{mk(cpts_pkg::FUNC_WRITE, 0, 5, 1, cpts_pkg::RUN_INTERRUPT, 3, 0, 0,
                        KILL_BIT, '1), 0, r});
    rows.push_back('{mk(cpts_pkg::FUNC_WRITE, 0, 6, 1, cpts_pkg::RUN_RUNNING, 1, 0, 1), 0, r});
    rows.push_back('{mk(cpts_pkg::FUNC_WRITE, 0, 7, 1, 3'd7, 127, 200), 0, r});
    rows.push_back('{mk(cpts_pkg::FUNC_TICK, 0, 0), 0, r});
    rows.push_back('{mk(cpts_pkg::FUNC_TICK, 0, 0), 0, r});
    rows.push_back('{mk(cpts_pkg::FUNC_SCHED, 0, 0), 0, r});
    rows.push_back('{mk(cpts_pkg::FUNC_READ, 0, 5), 0, r});
    rows.push_back('{mk(cpts_pkg::FUNC_READ, 0, 6), 0, r});
    rows.push_back('{mk(cpts_pkg::FUNC_WRITE, 0, 5), 0, r});
    rows.push_back('{mk(cpts_pkg::FUNC_WRITE, 0, 6), 0, r});
    rows.push_back('{mk(cpts_pkg::FUNC_WRITE, 0, 2, 1, cpts_pkg::RUN_RUNNING, 0, 0), 0, r});
    rows.push_back('{mk(cpts_pkg::FUNC_SCHED, 0, 0), 0, r});
    rows.push_back('{mk(cpts_pkg::FUNC_WRITE, 0, 2), 0, r});
    rows.push_back('{mk(cpts_pkg::FUNC_SCHED, 0, 0), 0, r});
    rows.push_back('{mk(cpts_pkg::FUNC_TICK, 1, 0), 0, r});
    rows.push_back('{mk(cpts_pkg::FUNC_TICK, 2, 0), 0, r});

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) begin
      rw = rows[i];
      transfer(rw.job, 0);
      r = apply_job(rw.job);
      pending_res.push_back(rw.typed ? rw.res : r);
    end

    for (int ph = 0; ph < 4; ph++) begin
      idle = ph == 1 ? 87 : ph == 3 ? 21 : 0;
      // hold off until every transfer has produced its result
      while (pending_res.size() != 0) @(negedge clk);
      for (int n = 0; n < 185; n++) begin
        job_t j;
        j = rand_job();
        transfer(j, idle);
        pending_res.push_back(apply_job(j));
      end
    end

    while (pending_res.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule
